FILE: design/spi_radio_transaction_decoder_assert.svh
// assertion macros for the spi radio transaction decoder checker
`ifndef SPI_RADIO_TRANSACTION_DECODER_ASSERT_SVH
`define SPI_RADIO_TRANSACTION_DECODER_ASSERT_SVH

// same-cycle implication, clk and rst_n taken from the enclosing scope
`define SRTD_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("srtd assertion failed");

// next-cycle implication
`define SRTD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("srtd assertion failed");

`endif

FILE: design/srtd_pkg.sv
// shared types, codes and command classification for the transaction decoder
package srtd_pkg;

  localparam int MAX_BURST = 256;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_END     = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_EXCESS  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CMD_WRITE       = 3'd0,
    CMD_BURST_WRITE = 3'd1,
    CMD_READ        = 3'd2,
    CMD_BURST_READ  = 3'd3,
    CMD_STROBE      = 3'd4,
    CMD_STATUS_READ = 3'd5,
    CMD_UNKNOWN     = 3'd6
  } cmd_t;

  typedef enum logic {
    ACT_BYTES  = 1'b0,
    ACT_SELECT = 1'b1
  } action_t;

  localparam logic [1:0] SEL_LOW     = 2'd0;
  localparam logic [1:0] SEL_UNKNOWN = 2'd2;

  typedef struct packed {
    kind_t       kind;
    cmd_t        cmd;
    logic [5:0]  addr;
    logic [7:0]  value;
    logic [7:0]  idx;
    logic [8:0]  total;
  } rec_t;

  function automatic cmd_t classify(input logic [7:0] b);
    logic [5:0] a;
    cmd_t       c;
    a = b[5:0];
    if (a < 6'h30 || a == 6'h3E || a == 6'h3F) begin
      unique case (b[7:6])
        2'b00:   c = CMD_WRITE;
        2'b01:   c = CMD_BURST_WRITE;
        2'b10:   c = CMD_READ;
        default: c = CMD_BURST_READ;
      endcase
    end else if (!b[6]) begin
      c = CMD_STROBE;
    end else if (b[7]) begin
      c = CMD_STATUS_READ;
    end else begin
      c = CMD_UNKNOWN;
    end
    return c;
  endfunction

  function automatic logic [8:0] limit_of(input cmd_t c);
    logic [8:0] l;
    unique case (c)
      CMD_WRITE, CMD_READ:      l = 9'd1;
      CMD_STROBE, CMD_UNKNOWN:  l = 9'd0;
      default:                  l = 9'(MAX_BURST);
    endcase
    return l;
  endfunction

  function automatic logic reads_miso(input cmd_t c);
    return c == CMD_READ || c == CMD_BURST_READ || c == CMD_STATUS_READ;
  endfunction

endpackage

FILE: design/srtd_front.sv
// front end: accepts input words, tracks the transaction and builds result records
module srtd_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic                                 in_tuser,
  input  logic [srtd_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 push,
  output srtd_pkg::rec_t                       push_rec
);
  import srtd_pkg::*;

  logic       expecting_r, expecting_nxt;
  logic       released_r, released_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [5:0] addr_r, addr_nxt;
  logic [8:0] count_r, count_nxt;

  logic [7:0] mosi, miso;
  logic       mv, sv, snew;
  logic [1:0] sold;
  cmd_t       cls;
  rec_t       rec;
  logic       emit;

  assign mosi = in_tdata[7:0];
  assign miso = in_tdata[15:8];
  assign mv   = in_tdata[16];
  assign sv   = in_tdata[17];
  assign sold = in_tdata[19:18];
  assign snew = in_tdata[20];
  assign cls  = classify(mosi);

  always_comb begin
    expecting_nxt = expecting_r;
    released_nxt  = released_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    count_nxt     = count_r;
    emit          = 1'b0;
    rec = '{kind: KIND_HEADER, cmd: CMD_WRITE, addr: '0, value: '0, idx: '0, total: '0};
    if (action_t'(in_tuser) == ACT_SELECT) begin
      if (sold == SEL_UNKNOWN && snew) begin
        released_nxt = 1'b1;
      end
      if (sold == SEL_LOW && snew) begin
        if (cmd_r != CMD_UNKNOWN && cmd_r != CMD_STROBE && count_r != 9'd0) begin
          emit      = 1'b1;
          rec.kind  = KIND_END;
          rec.cmd   = cmd_r;
          rec.addr  = addr_r;
          rec.total = count_r;
        end
        expecting_nxt = 1'b1;
        count_nxt     = '0;
        cmd_nxt       = CMD_UNKNOWN;
        released_nxt  = 1'b1;
      end
    end else if (released_r && mv && sv) begin
      if (expecting_r) begin
        expecting_nxt = 1'b0;
        cmd_nxt       = cls;
        addr_nxt      = mosi[5:0];
        count_nxt     = '0;
        emit          = 1'b1;
        rec.addr      = mosi[5:0];
        if (cls == CMD_UNKNOWN) begin
          rec.kind  = KIND_UNKNOWN;
          rec.value = mosi;
        end else begin
          rec.kind  = KIND_HEADER;
          rec.cmd   = cls;
          rec.value = miso;
        end
      end else if (cmd_r != CMD_UNKNOWN) begin
        emit      = 1'b1;
        rec.cmd   = cmd_r;
        rec.addr  = addr_r;
        rec.value = reads_miso(cmd_r) ? miso : mosi;
        if (count_r >= limit_of(cmd_r)) begin
          rec.kind = KIND_EXCESS;
        end else begin
          rec.kind  = KIND_DATA;
          rec.idx   = count_r[7:0];
          count_nxt = count_r + 9'd1;
        end
      end
    end
  end

  assign push     = accept && emit;
  assign push_rec = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expecting_r <= 1'b1;
      released_r  <= 1'b0;
      cmd_r       <= CMD_UNKNOWN;
      addr_r      <= '0;
      count_r     <= '0;
    end else if (accept) begin
      expecting_r <= expecting_nxt;
      released_r  <= released_nxt;
      cmd_r       <= cmd_nxt;
      addr_r      <= addr_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

FILE: design/srtd_queue.sv
// short record queue between the front end and the output stage
module srtd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srtd_pkg::rec_t push_rec,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output srtd_pkg::rec_t head
);
  import srtd_pkg::*;

  rec_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = cnt_r == (QAW+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign head    = q_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= push_rec;
    end
  end

endmodule

FILE: design/srtd_back.sv
// output stage: registers one record and formats the result word
module srtd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  srtd_pkg::rec_t                       q_head,
  output logic                                 pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [2:0]                           out_tuser,
  output logic [srtd_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import srtd_pkg::*;

  rec_t rec_r;
  logic vld_r, vld_nxt;
  logic hdr;

  assign pop     = !q_empty && (!vld_r || out_tready);
  assign vld_nxt = pop || (vld_r && !out_tready);
  assign hdr     = rec_r.kind == KIND_HEADER;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= q_head;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = rec_r.kind;
  assign out_tdata  = {6'd0,
                       rec_r.total,
                       rec_r.idx,
                       hdr ? rec_r.value[3:0] : 4'd0,
                       hdr ? rec_r.value[6:4] : 3'd0,
                       hdr ? rec_r.value[7] : 1'b0,
                       rec_r.value,
                       rec_r.addr,
                       rec_r.cmd};

endmodule

FILE: design/spi_radio_transaction_decoder.sv
// top level of the spi radio transaction decoder
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser action, tdata bytes, valid flags, select levels
//  out_    | out | out_tvalid/tready  | tuser kind, tdata command, status, index, total
//
// one input word per cycle while in_tready is high; a result goes through the record queue, then the output register
// the transaction state lives in the front end and updates as each word is taken
// a four-entry record queue and the output register let either side stall alone
// in_tready drops only while the queue is full; reset is synchronous, active low
module spi_radio_transaction_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic                                 in_tuser,   // action
  // ctrl_byte[7:0] radio_byte[15:8] mosi_valid[16] miso_valid[17]
  // select_old[19:18] select_new[20] zero[23:21]
  input  logic [srtd_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [2:0]                           out_tuser,  // kind
  // command_kind[2:0] register_address[8:3] value[16:9] chip_not_ready[17]
  // radio_state[20:18] fifo_bytes[24:21] byte_index[32:25] byte_total[41:33]
  // zero[47:42]
  output logic [srtd_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import srtd_pkg::*;

  logic accept, push, pop, q_full, q_empty;
  rec_t push_rec, q_head;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  srtd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .push     (push),
    .push_rec (push_rec)
  );

  srtd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  srtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: design/srtd_checker.sv
// port-level checker for the spi radio transaction decoder, with its bind
`include "spi_radio_transaction_decoder_assert.svh"

module srtd_port_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [2:0]                           out_tuser,
  input  logic [srtd_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import srtd_pkg::*;

  logic out_stall;
  logic not_hdr;
  logic is_end;
  logic is_data;

  assign out_stall = out_tvalid && !out_tready;
  assign not_hdr   = out_tvalid && out_tuser != KIND_HEADER;
  assign is_end    = out_tvalid && out_tuser == KIND_END;
  assign is_data   = out_tvalid && out_tuser == KIND_DATA;

  `SRTD_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata))
  `SRTD_ASSERT(a_status_hdr_only, not_hdr, out_tdata[24:17] == 8'd0)
  `SRTD_ASSERT(a_end_total, is_end, out_tdata[41:33] != 9'd0 && out_tdata[32:25] == 8'd0)
  `SRTD_ASSERT(a_data_no_total, is_data, out_tdata[41:33] == 9'd0)
  `SRTD_ASSERT(a_pad_zero, out_tvalid || in_tvalid || in_tready, out_tdata[47:42] == 6'd0)

endmodule

bind spi_radio_transaction_decoder srtd_port_checker u_srtd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
